@@ hdl/desu_pkg.sv @@
// Types, character codes and decode functions for the dollar-escape unescaper.
// No dependencies; used by the interfaces' users and the top level.
`timescale 1ns / 1ps
`default_nettype none

package desu_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CONSUMED_W = 16;
  localparam int unsigned MAX_RES    = 3;
  localparam int unsigned RES_IDX_W  = 2;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h27;
  localparam logic [BYTE_W-1:0] CH_LINE   = 8'h10;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DONE = 1'b1;
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_OPEN = 1'b1;

  typedef enum logic [4:0] {
    PH_SEEK   = 5'b00001,
    PH_BODY   = 5'b00010,
    PH_DOLLAR = 5'b00100,
    PH_HEX1   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic                  kind;
    logic [BYTE_W-1:0]     data;
    logic                  status;
    logic [CONSUMED_W-1:0] consumed;
  } desu_res_t;

  function automatic logic is_hex(input logic [BYTE_W-1:0] c);
    is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end
    hex_nibble = v[3:0];
  endfunction

  function automatic logic [BYTE_W-1:0] escape_map(input logic [BYTE_W-1:0] c);
    case (c) inside
      CH_QUOTE:     escape_map = CH_QUOTE;
      CH_DOLLAR:    escape_map = CH_DOLLAR;
      8'h4C, 8'h6C: escape_map = CH_LINE;
      8'h4E, 8'h6E: escape_map = CH_NL;
      8'h50, 8'h70: escape_map = CH_FF;
      8'h52, 8'h72: escape_map = CH_CR;
      8'h54, 8'h74: escape_map = CH_TAB;
      default:      escape_map = CH_NUL;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ hdl/desu_if.sv @@
// Valid/ready channel interfaces for the unescaper: text bytes in, results out.
// Standalone; payload widths are fixed by the text and result formats.
`timescale 1ns / 1ps
`default_nettype none

interface desu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface desu_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  out_byte;
  logic        status;
  logic [15:0] consumed;
  logic        run_end;

  modport source (output valid, output result_kind, output out_byte, output status,
                  output consumed, output run_end, input ready);
  modport sink   (input valid, input result_kind, input out_byte, input status,
                  input consumed, input run_end, output ready);
endinterface

`default_nettype wire

@@ hdl/dollar_escaped_string_unescaper.sv @@
// Unescaper for quoted string literals with dollar escapes: top level.
// Depends on desu_pkg and the channel interfaces in desu_if.sv.
// Takes one text byte per cycle while the result group is free into an input
// register, decodes it with the escape state in one pass and loads its zero
// to three results into a result group register that drains one result per
// cycle while the receiver is ready. A byte that gives at most one result then
// flows at one per cycle; one that gives more holds the input side until its
// group drains, the result group register being the only result buffer. Input
// passes the input register, then the result group register. Bytes ahead of the
// opening quote and after the closing quote give no result until the byte
// marked last. The consumed count saturates at 2^COUNT_WIDTH-1, reported clipped to 16 bits.
`timescale 1ns / 1ps
`default_nettype none

module dollar_escaped_string_unescaper
  import desu_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  desu_in_if.sink         req_i,
  desu_out_if.source      res_o
);

  localparam int unsigned ExtW = (COUNT_WIDTH > CONSUMED_W) ? COUNT_WIDTH : CONSUMED_W;

  // Input register
  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;
  logic              in_take;
  logic              proc;

  // Decode state
  phase_e                 phase_q, phase_d;
  logic [3:0]             held_q, held_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

  // Result group register
  desu_res_t              grp_q [MAX_RES];
  logic [RES_IDX_W-1:0]   grp_n_q, grp_idx_q, grp_idx_d;
  logic                   grp_valid_q, grp_valid_d;
  logic                   out_take, drain_last, group_free;

  // Decode outputs
  desu_res_t              res_d [MAX_RES];
  logic [RES_IDX_W-1:0]   n_d;
  logic                   body_go;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [ExtW-1:0]        cnt_ext;
  logic [CONSUMED_W-1:0]  cons_sat;
  phase_e                 phase_n;

  assign out_take   = grp_valid_q && res_o.ready;
  assign drain_last = out_take && (grp_idx_q == grp_n_q - RES_IDX_W'(1));
  assign group_free = !grp_valid_q || drain_last;
  assign proc       = in_valid_q && group_free;
  assign req_i.ready = !in_valid_q || group_free;
  assign in_take    = req_i.valid && req_i.ready;

  assign in_valid_d = in_take ? 1'b1 : (proc ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= req_i.in_byte;
      in_last_q <= req_i.last_byte;
    end
  end

  // Saturating position count, already including the current byte
  assign cnt_inc  = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
  assign cnt_ext  = ExtW'(cnt_inc);
  assign cons_sat = (cnt_ext > ExtW'({CONSUMED_W{1'b1}})) ? {CONSUMED_W{1'b1}}
                                                          : cnt_ext[CONSUMED_W-1:0];

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res_d[i] = '0;
    end
    n_d     = '0;
    body_go = 1'b0;
    phase_n = phase_q;
    held_d  = held_q;
    cnt_d   = cnt_inc;

    unique case (phase_q)
      PH_SEEK: begin
        if (in_byte_q == CH_QUOTE) phase_n = PH_BODY;
      end
      PH_BODY: begin
        body_go = 1'b1;
      end
      PH_DOLLAR: begin
        if (is_hex(in_byte_q)) begin
          held_d  = hex_nibble(in_byte_q);
          phase_n = PH_HEX1;
        end else begin
          res_d[n_d].kind = KIND_DATA;
          res_d[n_d].data = escape_map(in_byte_q);
          n_d     = n_d + RES_IDX_W'(1);
          phase_n = PH_BODY;
        end
      end
      PH_HEX1: begin
        res_d[n_d].kind = KIND_DATA;
        phase_n = PH_BODY;
        if (is_hex(in_byte_q)) begin
          res_d[n_d].data = {held_q, hex_nibble(in_byte_q)};
        end else begin
          // Lone hex digit: drop to zero and reprocess this byte as body text
          res_d[n_d].data = CH_NUL;
          body_go = 1'b1;
        end
        n_d = n_d + RES_IDX_W'(1);
      end
      PH_DONE: begin
        phase_n = PH_DONE;
      end
      default: begin
        phase_n = PH_DONE;
      end
    endcase

    if (body_go) begin
      if (in_byte_q == CH_DOLLAR) begin
        phase_n = PH_DOLLAR;
      end else if (in_byte_q == CH_QUOTE) begin
        res_d[n_d].kind     = KIND_DONE;
        res_d[n_d].status   = STAT_OK;
        res_d[n_d].consumed = cons_sat;
        n_d     = n_d + RES_IDX_W'(1);
        phase_n = PH_DONE;
      end else begin
        res_d[n_d].kind = KIND_DATA;
        res_d[n_d].data = in_byte_q;
        n_d = n_d + RES_IDX_W'(1);
      end
    end

    phase_d = phase_n;
    if (in_last_q) begin
      // Escape cut short by end of text
      if (phase_n == PH_DOLLAR || phase_n == PH_HEX1) begin
        res_d[n_d].kind = KIND_DATA;
        res_d[n_d].data = CH_NUL;
        n_d = n_d + RES_IDX_W'(1);
      end
      if (phase_n != PH_DONE) begin
        res_d[n_d].kind   = KIND_DONE;
        res_d[n_d].status = STAT_OPEN;
        n_d = n_d + RES_IDX_W'(1);
      end
      phase_d = PH_SEEK;
      held_d  = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
      held_q  <= '0;
      cnt_q   <= '0;
    end else if (proc) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      cnt_q   <= cnt_d;
    end
  end

  // Result group: load on a decoded byte with results, advance on each handoff
  always_comb begin
    grp_valid_d = grp_valid_q;
    grp_idx_d   = grp_idx_q;
    if (out_take) grp_idx_d = grp_idx_q + RES_IDX_W'(1);
    if (drain_last) grp_valid_d = 1'b0;
    if (proc && (n_d != '0)) begin
      grp_valid_d = 1'b1;
      grp_idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      grp_idx_q   <= '0;
      grp_n_q     <= '0;
    end else begin
      grp_valid_q <= grp_valid_d;
      grp_idx_q   <= grp_idx_d;
      if (proc && (n_d != '0)) grp_n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && (n_d != '0)) begin
      for (int i = 0; i < MAX_RES; i++) begin
        grp_q[i] <= res_d[i];
      end
    end
  end

  assign res_o.valid       = grp_valid_q;
  assign res_o.result_kind = grp_q[grp_idx_q].kind;
  assign res_o.out_byte    = grp_q[grp_idx_q].data;
  assign res_o.status      = grp_q[grp_idx_q].status;
  assign res_o.consumed    = grp_q[grp_idx_q].consumed;
  assign res_o.run_end     = (grp_idx_q == grp_n_q - RES_IDX_W'(1));

`ifndef NO_ASSERTIONS
  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q |-> (grp_n_q != '0) && (grp_idx_q < grp_n_q))
    else $error("result index outside loaded group");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grp_valid_q && grp_q[grp_idx_q].kind == KIND_DONE) |-> res_o.run_end)
    else $error("completion is not the final result of its byte");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_last && !(proc && (n_d != '0))) |=> !grp_valid_q)
    else $error("group still valid after final result handed off");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |-> group_free)
    else $error("byte decoded while result group still held");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("decode phase lost one-hot coding");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the dollar-escape string unescaper.
// Depends on desu_pkg, the channel interfaces in desu_if.sv and the top level.
// Feeds directed and random texts, predicts every result and checks it in order.
`timescale 1ns / 1ps

module tb;
  import desu_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned TEXT_ITEMS   = 150;
  localparam int unsigned HOLD_AT      = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic                  kind;
    logic [BYTE_W-1:0]     data;
    logic                  status;
    logic [CONSUMED_W-1:0] consumed;
    logic                  run_end;
  } text_res_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } text_byte_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  desu_in_if  req_if ();
  desu_out_if res_if ();

  dollar_escaped_string_unescaper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .res_o  (res_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_byte_t text_q[$];
  text_res_t  decoded_q[$];

  // decoder state mirrored on the bench side
  phase_e                ph       = PH_SEEK;
  logic [3:0]            hi_nib   = '0;
  logic [CONSUMED_W-1:0] seen_cnt = '0;
  text_res_t             held_res;
  logic                  have_held;

  int unsigned n_errors   = 0;
  int unsigned n_accepted = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left  = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;
  int unsigned gen_items  = 0;

  string esc_set = "LlNnPpRrTt'$";
  string hex_set = "0123456789abcdefABCDEF";

  function automatic int nibble_of(input logic [BYTE_W-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    return -1;
  endfunction

  function automatic logic [BYTE_W-1:0] escaped_char(input logic [BYTE_W-1:0] c);
    case (c)
      CH_QUOTE:     return CH_QUOTE;
      CH_DOLLAR:    return CH_DOLLAR;
      8'h4C, 8'h6C: return CH_LINE;  // L l
      8'h4E, 8'h6E: return CH_NL;    // N n
      8'h50, 8'h70: return CH_FF;    // P p
      8'h52, 8'h72: return CH_CR;    // R r
      8'h54, 8'h74: return CH_TAB;   // T t
      default:      return CH_NUL;
    endcase
  endfunction

  // hold back the newest result so the final one of a request gets run_end
  function void emit_res(input logic k, input logic [BYTE_W-1:0] d, input logic s,
                         input logic [CONSUMED_W-1:0] n);
    if (have_held) decoded_q.push_back(held_res);
    held_res  = '{kind: k, data: d, status: s, consumed: n, run_end: 1'b0};
    have_held = 1'b1;
  endfunction

  function void body_char(input logic [BYTE_W-1:0] c);
    if (c == CH_DOLLAR) begin
      ph = PH_DOLLAR;
    end else if (c == CH_QUOTE) begin
      emit_res(KIND_DONE, CH_NUL, STAT_OK, seen_cnt);
      ph = PH_DONE;
    end else begin
      emit_res(KIND_DATA, c, STAT_OK, '0);
    end
  endfunction

  function void predict_byte(input logic [BYTE_W-1:0] c, input logic last);
    int nib;
    have_held = 1'b0;
    nib = nibble_of(c);
    if (seen_cnt != '1) seen_cnt = seen_cnt + 1'b1;
    case (ph)
      PH_SEEK: begin
        if (c == CH_QUOTE) ph = PH_BODY;
      end
      PH_BODY: body_char(c);
      PH_DOLLAR: begin
        if (nib >= 0) begin
          hi_nib = nib[3:0];
          ph = PH_HEX1;
        end else begin
          emit_res(KIND_DATA, escaped_char(c), STAT_OK, '0);
          ph = PH_BODY;
        end
      end
      PH_HEX1: begin
        ph = PH_BODY;
        if (nib >= 0) begin
          emit_res(KIND_DATA, {hi_nib, nib[3:0]}, STAT_OK, '0);
        end else begin
          // lone hex digit: zero byte, then handle this byte as body text
          emit_res(KIND_DATA, CH_NUL, STAT_OK, '0);
          body_char(c);
        end
      end
      default: ;
    endcase
    if (last) begin
      if (ph == PH_DOLLAR || ph == PH_HEX1) emit_res(KIND_DATA, CH_NUL, STAT_OK, '0);
      if (ph != PH_DONE) emit_res(KIND_DONE, CH_NUL, STAT_OPEN, '0);
      ph       = PH_SEEK;
      hi_nib   = '0;
      seen_cnt = '0;
    end
    if (have_held) begin
      held_res.run_end = 1'b1;
      decoded_q.push_back(held_res);
    end
  endfunction

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom_range(1, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] noise_byte();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1) ? CH_QUOTE : CH_DOLLAR;
    return any_byte();
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte(input logic allow_hex);
    logic [BYTE_W-1:0] c;
    do begin
      c = any_byte();
    end while (c == CH_QUOTE || c == CH_DOLLAR || (!allow_hex && nibble_of(c) >= 0));
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] hex_char();
    return hex_set[$urandom_range(0, hex_set.len() - 1)];
  endfunction

  function void add_byte(input logic [BYTE_W-1:0] c, input logic last);
    text_q.push_back('{ch: c, last: last});
    gen_items++;
  endfunction

  function void add_str(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], last && (i == s.len() - 1));
  endfunction

  // mostly well-formed literals with random content, some noise and cut texts
  function void gen_text();
    int unsigned n;
    int unsigned tail;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      for (int unsigned i = 0; i < n; i++) add_byte(noise_byte(), i == n - 1);
      return;
    end
    n = $urandom_range(0, 2);
    for (int unsigned i = 0; i < n; i++) add_byte(plain_byte(1'b1), 1'b0);
    add_byte(CH_QUOTE, 1'b0);
    n = $urandom_range(0, 6);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_byte(plain_byte(1'b1), 1'b0);
        4, 5: begin
          add_byte(CH_DOLLAR, 1'b0);
          add_byte(esc_set[$urandom_range(0, esc_set.len() - 1)], 1'b0);
        end
        6, 7: begin
          add_byte(CH_DOLLAR, 1'b0);
          add_byte(hex_char(), 1'b0);
          add_byte(hex_char(), 1'b0);
        end
        8: begin
          add_byte(CH_DOLLAR, 1'b0);
          add_byte(hex_char(), 1'b0);
          add_byte(plain_byte(1'b0), 1'b0);
        end
        default: begin
          add_byte(CH_DOLLAR, 1'b0);
          add_byte(any_byte(), 1'b0);
        end
      endcase
    end
    case ($urandom_range(0, 9))
      7: add_byte(plain_byte(1'b1), 1'b1);
      8: add_byte(CH_DOLLAR, 1'b1);
      9: begin
        add_byte(CH_DOLLAR, 1'b0);
        add_byte(hex_char(), 1'b1);
      end
      default: begin
        tail = $urandom_range(0, 2);
        add_byte(CH_QUOTE, tail == 0);
        for (int unsigned i = 0; i < tail; i++) add_byte(noise_byte(), i == tail - 1);
      end
    endcase
  endfunction

  // request driver: predict on acceptance, then offer the next pending byte
  always @(posedge clk_i) begin
    text_byte_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left     <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_byte(req_if.in_byte, req_if.last_byte);
        n_accepted <= n_accepted + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0 && hold_left == 0) begin
          gap_left     <= gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (text_q.size() != 0) begin
          nxt = text_q.pop_front();
          req_if.valid     <= 1'b1;
          req_if.in_byte   <= nxt.ch;
          req_if.last_byte <= nxt.last;
          gap_left         <= idle_len();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // result monitor and ready generator
  always @(posedge clk_i) begin
    text_res_t got;
    text_res_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
      calm_left    <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{kind: res_if.result_kind, data: res_if.out_byte, status: res_if.status,
                consumed: res_if.consumed, run_end: res_if.run_end};
        if (decoded_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("unexpected result: kind=%0b byte=%02h status=%0b consumed=%0d end=%0b",
                     got.kind, got.data, got.status, got.consumed, got.run_end);
        end else begin
          want = decoded_q.pop_front();
          if (got.kind !== want.kind || got.data !== want.data || got.status !== want.status ||
              got.consumed !== want.consumed || got.run_end !== want.run_end) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("mismatch: expected kind=%0b byte=%02h status=%0b consumed=%0d end=%0b",
                       want.kind, want.data, want.status, want.consumed, want.run_end);
              $display("          got      kind=%0b byte=%02h status=%0b consumed=%0d end=%0b",
                       got.kind, got.data, got.status, got.consumed, got.run_end);
            end
          end
        end
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left    <= calm_left - 1;
        res_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 19) == 0) calm_left <= 40;
        else stall_left <= idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    req_if.valid     = 1'b0;
    req_if.in_byte   = '0;
    req_if.last_byte = 1'b0;
    res_if.ready     = 1'b0;

    // preamble, hex escape in mixed case, quote and dollar escapes, ignored tail
    add_byte(8'hFF, 1'b0);
    add_str("'$Af$'$$'", 1'b0);
    add_byte(8'h80, 1'b1);
    // lone hex digit cut by the closing quote; last byte after the close
    add_str("'$1'", 1'b0);
    add_byte(8'h01, 1'b1);
    // unknown escape, then text ending right after a dollar
    add_str("'$Z$", 1'b1);
    // no quote at all
    add_byte(8'h51, 1'b1);
    // text ending after a dollar and one hex digit
    add_str("'$7", 1'b1);
    // opening quote is the last byte
    add_byte(CH_QUOTE, 1'b1);

    while (gen_items < TEXT_ITEMS) gen_text();
    for (int i = 0; i < 3; i++) gen_text();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || req_if.valid || decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (decoded_q.size() != 0) begin
      $display("%0d expected results never arrived", decoded_q.size());
      n_errors += decoded_q.size();
    end
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
